// ===== hw/rtl/tat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types and codes for the trusted address table: command bytes,
// result status codes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package tat_pkg;

    localparam logic [7:0] CMD_ADD    = 8'h01;
    localparam logic [7:0] CMD_REMOVE = 8'h02;
    localparam logic [7:0] CMD_SCORE  = 8'h03;

    typedef enum logic [3:0] {
        ST_CHECKED   = 4'd0,
        ST_ADDED     = 4'd1,
        ST_DUPLICATE = 4'd2,
        ST_FULL      = 4'd3,
        ST_REMOVED   = 4'd4,
        ST_NOT_FOUND = 4'd5,
        ST_SCORE_SET = 4'd6,
        ST_SHORT     = 4'd7,
        ST_UNKNOWN   = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        OP_CHECK,
        OP_ADD,
        OP_REMOVE
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    step;
        logic    shift_wr;
        logic    append;
        logic    cnt_dec;
        logic    score_wr;
        logic    out_load;
        logic    out_trusted;
        t_status out_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic scan_end;
        logic full;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/tat_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tat_ctrl
// Sequencer for the trusted address table. Decodes each request, steers the
// scan and the compaction pass in the datapath, and picks the result status.
// ----------------------------------------------------------------------------
module tat_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_func,
    input  wire logic [7:0]       i_command,
    input  wire logic             i_payload_ok,
    input  wire tat_pkg::t_dp_sts i_sts,
    output tat_pkg::t_dp_cmd      o_cmd
);

    tat_pkg::t_state  r_state,   n_state;
    tat_pkg::t_op     r_op,      n_op;
    tat_pkg::t_status r_status,  n_status;
    logic             r_trusted, n_trusted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tat_pkg::S_IDLE;
            r_op      <= tat_pkg::OP_CHECK;
            r_status  <= tat_pkg::ST_CHECKED;
            r_trusted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_status  <= n_status;
            r_trusted <= n_trusted;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_status  = r_status;
        n_trusted = r_trusted;
        o_cmd     = '0;
        case (r_state)
            tat_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_trusted  = 1'b0;
                    n_status   = tat_pkg::ST_CHECKED;
                    if (!i_func) begin
                        n_op    = tat_pkg::OP_CHECK;
                        n_state = tat_pkg::S_SCAN;
                    end else if (i_command != tat_pkg::CMD_ADD &&
                                 i_command != tat_pkg::CMD_REMOVE &&
                                 i_command != tat_pkg::CMD_SCORE) begin
                        n_status = tat_pkg::ST_UNKNOWN;
                        n_state  = tat_pkg::S_FINISH;
                    end else if (!i_payload_ok) begin
                        n_status = tat_pkg::ST_SHORT;
                        n_state  = tat_pkg::S_FINISH;
                    end else if (i_command == tat_pkg::CMD_SCORE) begin
                        o_cmd.score_wr = 1'b1;
                        n_status       = tat_pkg::ST_SCORE_SET;
                        n_state        = tat_pkg::S_FINISH;
                    end else if (i_command == tat_pkg::CMD_ADD) begin
                        n_op    = tat_pkg::OP_ADD;
                        n_state = tat_pkg::S_SCAN;
                    end else begin
                        n_op    = tat_pkg::OP_REMOVE;
                        n_state = tat_pkg::S_SCAN;
                    end
                end
            end
            tat_pkg::S_SCAN: begin
                if (i_sts.hit) begin
                    case (r_op)
                        tat_pkg::OP_CHECK: begin
                            n_trusted = 1'b1;
                            n_status  = tat_pkg::ST_CHECKED;
                            n_state   = tat_pkg::S_FINISH;
                        end
                        tat_pkg::OP_ADD: begin
                            n_status = tat_pkg::ST_DUPLICATE;
                            n_state  = tat_pkg::S_FINISH;
                        end
                        default: begin
                            // Start pulling the later entries down one slot.
                            o_cmd.step = 1'b1;
                            n_state    = tat_pkg::S_SHIFT;
                        end
                    endcase
                end else if (i_sts.scan_end) begin
                    case (r_op)
                        tat_pkg::OP_CHECK: begin
                            n_status = tat_pkg::ST_CHECKED;
                        end
                        tat_pkg::OP_ADD: begin
                            if (i_sts.full) begin
                                n_status = tat_pkg::ST_FULL;
                            end else begin
                                o_cmd.append = 1'b1;
                                n_status     = tat_pkg::ST_ADDED;
                            end
                        end
                        default: begin
                            n_status = tat_pkg::ST_NOT_FOUND;
                        end
                    endcase
                    n_state = tat_pkg::S_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            tat_pkg::S_SHIFT: begin
                if (i_sts.scan_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_status      = tat_pkg::ST_REMOVED;
                    n_state       = tat_pkg::S_FINISH;
                end else begin
                    o_cmd.shift_wr = 1'b1;
                    o_cmd.step     = 1'b1;
                end
            end
            tat_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tat_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tat_pkg::S_IDLE;
            end
        endcase
        o_cmd.out_trusted = r_trusted;
        o_cmd.out_status  = r_status;
    end

    assign o_ready = (r_state == tat_pkg::S_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/tat_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tat_dpath
// Datapath of the trusted address table: address memory with a registered
// read port, scan pointer and compare stage, entry count, score register and
// the result register.
// ----------------------------------------------------------------------------
module tat_dpath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_func,
    input  wire logic [31:0]      i_source_address,
    input  wire logic [31:0]      i_payload_word,
    input  wire logic             i_ready,
    input  wire tat_pkg::t_dp_cmd i_cmd,
    output tat_pkg::t_dp_sts      o_sts,
    output logic                  o_valid,
    output logic                  o_is_trusted,
    output logic [3:0]            o_status,
    output logic [4:0]            o_entry_count,
    output logic [31:0]           o_security_score
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    logic [31:0]      mem [TABLE_DEPTH];
    logic [31:0]      r_key;
    logic [31:0]      r_rd_data;
    logic [CNT_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_score;
    logic             r_out_valid;

    logic             rd_go;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic [CNT_W-1:0] shift_addr;
    logic [CNT_W+4:0] cnt_ext;

    assign rd_go      = i_cmd.step && (r_rd_idx < r_count);
    assign shift_addr = r_cmp_idx - 1'b1;
    assign wr_en      = i_cmd.append || (i_cmd.shift_wr && r_cmp_vld);
    assign wr_addr    = i_cmd.append ? r_count[IDX_W-1:0] : shift_addr[IDX_W-1:0];
    assign wr_data    = i_cmd.append ? r_key : r_rd_data;
    assign cnt_ext    = {5'd0, r_count};

    assign o_sts.hit      = r_cmp_vld && (r_rd_data == r_key);
    assign o_sts.scan_end = !r_cmp_vld && (r_rd_idx >= r_count);
    assign o_sts.full     = (r_count >= DEPTH_CNT);
    assign o_sts.out_free = !r_out_valid || i_ready;

    // Address memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_go) begin
            r_rd_data <= mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_func ? i_payload_word : i_source_address;
        end
        if (i_cmd.step && rd_go) begin
            r_cmp_idx <= r_rd_idx;
        end
        if (i_cmd.out_load) begin
            o_is_trusted     <= i_cmd.out_trusted;
            o_status         <= i_cmd.out_status;
            o_entry_count    <= cnt_ext[4:0];
            o_security_score <= r_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_cmp_vld   <= 1'b0;
            r_count     <= '0;
            r_score     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.step) begin
                if (rd_go) begin
                    r_rd_idx  <= r_rd_idx + 1'b1;
                    r_cmp_vld <= 1'b1;
                end else begin
                    r_cmp_vld <= 1'b0;
                end
            end
            if (i_cmd.append) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.score_wr) begin
                r_score <= i_payload_word;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("entry count above table depth");
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_count < DEPTH_CNT))
        else $error("append into a full table");
    a_dec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> (r_count != '0))
        else $error("remove from an empty table");
    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift_wr && r_cmp_vld) |-> (r_cmp_idx != '0 && r_cmp_idx < r_count))
        else $error("compaction write outside the valid entries");
    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(o_status)))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/trusted_address_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trusted_address_table_top
// A check, add or remove scans the stored entries before its result is
// valid; score, short and unknown requests go straight to the result.
// Requests are taken one at a time; the scan reads one entry a cycle
// through the single memory read port.
// Reset: synchronous, clears the entry count, the score and all handshakes.
// ----------------------------------------------------------------------------
module trusted_address_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request channel.
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_func,
    input  wire logic [31:0] i_source_address,
    input  wire logic [7:0]  i_command,
    input  wire logic [31:0] i_payload_word,
    input  wire logic        i_payload_ok,
    // Result channel.
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_is_trusted,
    output logic [3:0]       o_status,
    output logic [4:0]       o_entry_count,
    output logic [31:0]      o_security_score
);

    // The controller decodes a request in the cycle it is accepted. Checks,
    // adds and removes then walk the compact list from entry zero; the
    // memory read is pipelined so one entry is compared each cycle. A remove
    // that finds its address keeps the same read pointer running and writes
    // each later entry one slot down, then drops the count.
    //
    // The result sits in a register of its own, so a new request is taken
    // as soon as the controller is back in idle, even while the previous
    // result still waits for the consumer.
    tat_pkg::t_dp_cmd dp_cmd;
    tat_pkg::t_dp_sts dp_sts;

    tat_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_command    (i_command),
        .i_payload_ok (i_payload_ok),
        .i_sts        (dp_sts),
        .o_cmd        (dp_cmd)
    );

    // The address entries are never cleared; only entries below the count
    // are ever read, so their power-up contents cannot reach a result.
    tat_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_func           (i_func),
        .i_source_address (i_source_address),
        .i_payload_word   (i_payload_word),
        .i_ready          (i_ready),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .o_valid          (o_valid),
        .o_is_trusted     (o_is_trusted),
        .o_status         (o_status),
        .o_entry_count    (o_entry_count),
        .o_security_score (o_security_score)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for trusted_address_table_top. Requests (checks and
// add/remove/score commands) come from a queue that is built at time zero.
// The bench first runs a short list of corner cases and then random
// episodes that fill the table, drain it, mix operations and inject bad
// commands. A behavioral copy of the address list and the score predicts
// each result when its request is accepted. Results are compared field by
// field in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_DEPTH = 16;
    localparam int TARGET_ITEMS = 1950;
    // Worst idle stretch is roughly a long sender gap, a full scan and a long
    // receiver stall; the limit allows many times that.
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 4);

    localparam logic FUNC_CHECK = 1'b0;
    localparam logic FUNC_COMMAND = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] source_address;
        logic [7:0]  command;
        logic [31:0] payload_word;
        logic        payload_ok;
    } t_request;

    typedef struct packed {
        logic             is_trusted;
        tat_pkg::t_status status;
        logic [4:0]       entry_count;
        logic [31:0]      security_score;
    } t_table_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_func = 1'b0;
    logic [31:0] i_source_address = '0;
    logic [7:0]  i_command = '0;
    logic [31:0] i_payload_word = '0;
    logic        i_payload_ok = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_is_trusted;
    logic [3:0]  o_status;
    logic [4:0]  o_entry_count;
    logic [31:0] o_security_score;

    int          mismatches = 0;

    trusted_address_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_source_address(i_source_address),
        .i_command       (i_command),
        .i_payload_word  (i_payload_word),
        .i_payload_ok    (i_payload_ok),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_is_trusted    (o_is_trusted),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_security_score(o_security_score)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Reset is held from time zero and released on a falling edge.
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Predicted table state. It follows the accepted requests, so it always
    // matches what the block should hold once those requests are done.
    // ------------------------------------------------------------------------
    logic [31:0]   trusted_list [TABLE_DEPTH];
    int            list_len = 0;
    logic [31:0]   score_reg = '0;
    t_table_result expected_results[$];

    // Index of addr among the valid entries, or -1 when it is absent.
    function automatic int find_address(input logic [31:0] addr);
        for (int k = 0; k < list_len; k++) begin
            if (trusted_list[k] == addr) return k;
        end
        return -1;
    endfunction

    function automatic t_table_result predict_table(input t_request req);
        t_table_result res;
        int            hit;
        res.is_trusted = 1'b0;
        res.status = tat_pkg::ST_CHECKED;
        if (req.func == FUNC_CHECK) begin
            // The command fields are don't-care on a check.
            res.is_trusted = (find_address(req.source_address) >= 0);
        end else if (req.command != tat_pkg::CMD_ADD && req.command != tat_pkg::CMD_REMOVE
                     && req.command != tat_pkg::CMD_SCORE) begin
            // An unknown command wins over a short payload.
            res.status = tat_pkg::ST_UNKNOWN;
        end else if (!req.payload_ok) begin
            res.status = tat_pkg::ST_SHORT;
        end else if (req.command == tat_pkg::CMD_ADD) begin
            // The duplicate test comes before the full test.
            if (find_address(req.payload_word) >= 0) begin
                res.status = tat_pkg::ST_DUPLICATE;
            end else if (list_len >= TABLE_DEPTH) begin
                res.status = tat_pkg::ST_FULL;
            end else begin
                trusted_list[list_len] = req.payload_word;
                list_len++;
                res.status = tat_pkg::ST_ADDED;
            end
        end else if (req.command == tat_pkg::CMD_REMOVE) begin
            hit = find_address(req.payload_word);
            if (hit < 0) begin
                res.status = tat_pkg::ST_NOT_FOUND;
            end else begin
                // Later entries move down one place to keep the list compact.
                for (int k = hit; k + 1 < list_len; k++) begin
                    trusted_list[k] = trusted_list[k + 1];
                end
                list_len--;
                res.status = tat_pkg::ST_REMOVED;
            end
        end else begin
            score_reg = req.payload_word;
            res.status = tat_pkg::ST_SCORE_SET;
        end
        res.entry_count = 5'(list_len);
        res.security_score = score_reg;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus. The planned list mirrors what the table will hold after the
    // requests queued so far. The generator uses it to pick addresses that
    // are present, so removes and checks hit real entries most of the time.
    // ------------------------------------------------------------------------
    t_request    pending_requests[$];
    logic [31:0] planned_list[$];
    int          planned_items = 0;

    task automatic queue_request(input logic func, input logic [31:0] src,
                                 input logic [7:0] cmd, input logic [31:0] word,
                                 input logic ok);
        t_request req;
        int       idx;
        req = '{func, src, cmd, word, ok};
        pending_requests.push_back(req);
        planned_items++;
        if (func == FUNC_COMMAND && ok) begin
            idx = -1;
            foreach (planned_list[k]) begin
                if (planned_list[k] == word && idx < 0) idx = k;
            end
            if (cmd == tat_pkg::CMD_ADD && idx < 0 && planned_list.size() < TABLE_DEPTH) begin
                planned_list.push_back(word);
            end
            if (cmd == tat_pkg::CMD_REMOVE && idx >= 0) begin
                planned_list.delete(idx);
            end
        end
    endtask

    // A check carries random junk in the fields that it ignores.
    task automatic queue_check(input logic [31:0] addr);
        queue_request(FUNC_CHECK, addr, 8'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic queue_command(input logic [7:0] cmd, input logic [31:0] word,
                                 input logic ok);
        queue_request(FUNC_COMMAND, $urandom, cmd, word, ok);
    endtask

    function automatic logic [31:0] known_address();
        if (planned_list.size() == 0) return $urandom;
        return planned_list[$urandom_range(0, planned_list.size() - 1)];
    endfunction

    // Mostly random words, with the all-zero and all-one words and one-bit
    // neighbors of stored entries mixed in to catch partial compares.
    function automatic logic [31:0] fresh_address();
        logic [31:0] addr;
        addr = $urandom;
        case ($urandom_range(0, 9))
            0: addr = 32'h0000_0000;
            1: addr = 32'hFFFF_FFFF;
            2: if (planned_list.size() != 0) begin
                addr = known_address() ^ (32'h1 << $urandom_range(0, 31));
            end
            default: ;
        endcase
        return addr;
    endfunction

    function automatic logic [31:0] any_address();
        return $urandom_range(0, 1) ? known_address() : fresh_address();
    endfunction

    // Adds until the table is full, then pushes against the limit.
    task automatic fill_table();
        int guard;
        guard = 0;
        while (planned_list.size() < TABLE_DEPTH && guard < 48) begin
            queue_command(tat_pkg::CMD_ADD, fresh_address(), 1'b1);
            if ($urandom_range(0, 3) == 0) queue_check(any_address());
            guard++;
        end
        repeat ($urandom_range(1, 3)) queue_command(tat_pkg::CMD_ADD, any_address(), 1'b1);
    endtask

    // Short payloads on real commands, unknown commands, and checks.
    task automatic queue_noise();
        logic [7:0] cmd;
        case ($urandom_range(0, 2))
            0: begin
                case ($urandom_range(0, 2))
                    0: cmd = tat_pkg::CMD_ADD;
                    1: cmd = tat_pkg::CMD_REMOVE;
                    default: cmd = tat_pkg::CMD_SCORE;
                endcase
                queue_command(cmd, any_address(), 1'b0);
            end
            1: begin
                do begin
                    cmd = 8'($urandom);
                end while (cmd == tat_pkg::CMD_ADD || cmd == tat_pkg::CMD_REMOVE
                           || cmd == tat_pkg::CMD_SCORE);
                queue_command(cmd, any_address(), 1'($urandom));
            end
            default: queue_check($urandom);
        endcase
    endtask

    initial begin
        // Corner cases: empty table, word extremes, duplicates, bad commands,
        // removal at the head and removal of a missing entry.
        queue_check(32'h0000_0000);
        queue_check(32'hFFFF_FFFF);
        queue_command(tat_pkg::CMD_SCORE, 32'hFFFF_FFFF, 1'b1);
        queue_command(tat_pkg::CMD_ADD, 32'h0000_0000, 1'b1);
        queue_command(tat_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b1);
        queue_command(tat_pkg::CMD_ADD, 32'hFFFF_FFFF, 1'b1);
        queue_check(32'hFFFF_FFFF);
        queue_check(32'hFFFF_FFFE);
        queue_check(32'h0000_0000);
        queue_command(tat_pkg::CMD_ADD, 32'h1234_5678, 1'b0);
        queue_command(tat_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0);
        queue_command(tat_pkg::CMD_SCORE, 32'h0000_0000, 1'b0);
        queue_command(8'h00, 32'hFFFF_FFFF, 1'b1);
        queue_command(8'hFF, 32'h0000_0000, 1'b0);
        queue_command(8'h04, 32'h1234_5678, 1'b1);
        queue_command(tat_pkg::CMD_REMOVE, 32'h0000_0000, 1'b1);
        queue_command(tat_pkg::CMD_REMOVE, 32'h0000_0000, 1'b1);
        queue_check(32'h0000_0000);
        queue_check(32'hFFFF_FFFF);
        queue_command(tat_pkg::CMD_SCORE, 32'h0000_0000, 1'b1);

        // Random episodes. The first one always fills the table so that the
        // full case is reached early.
        fill_table();
        while (planned_items < TARGET_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: fill_table();
                3, 4, 5: begin
                    // Drain in random order: head, middle and tail entries,
                    // plus the odd address that is not there.
                    repeat ($urandom_range(1, planned_list.size() + 2)) begin
                        if ($urandom_range(0, 3) != 0) begin
                            queue_command(tat_pkg::CMD_REMOVE, known_address(), 1'b1);
                        end else begin
                            queue_command(tat_pkg::CMD_REMOVE, fresh_address(), 1'b1);
                        end
                        if ($urandom_range(0, 2) == 0) queue_check(any_address());
                    end
                end
                6, 7, 8: begin
                    repeat (20) begin
                        case ($urandom_range(0, 5))
                            0: queue_check(known_address());
                            1: queue_check(fresh_address());
                            2: queue_command(tat_pkg::CMD_ADD, fresh_address(), 1'b1);
                            3: queue_command(tat_pkg::CMD_REMOVE, known_address(), 1'b1);
                            4: queue_command(tat_pkg::CMD_SCORE, $urandom, 1'b1);
                            default: queue_noise();
                        endcase
                    end
                end
                default: repeat ($urandom_range(3, 8)) queue_noise();
            endcase
        end

        // Every request handed over, every result back, then a quiet spell
        // to catch any stray result.
        while (pending_requests.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("trusted_address_table_top regression: pass");
        end else begin
            $display("trusted_address_table_top regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Idle pattern: mostly no gap or a short one, now and then a long one,
    // and occasional runs with no idling at all.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request driver. It works on the falling edge. req_taken tells it
    // whether the request on the bus went through at the last rising edge.
    logic     req_taken = 1'b0;
    int       req_gap = 0;
    int       req_quiet = 0;
    t_request next_req;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !req_taken) begin
            // The request is still waiting, so valid and payload stay put.
        end else if (req_gap > 0) begin
            i_valid <= 1'b0;
            req_gap--;
        end else if (pending_requests.size() != 0) begin
            next_req = pending_requests.pop_front();
            i_func <= next_req.func;
            i_source_address <= next_req.source_address;
            i_command <= next_req.command;
            i_payload_word <= next_req.payload_word;
            i_payload_ok <= next_req.payload_ok;
            i_valid <= 1'b1;
            if (req_quiet > 0) begin
                req_gap = 0;
                req_quiet--;
            end else begin
                req_gap = pick_gap();
                if ($urandom_range(0, 39) == 0) req_quiet = $urandom_range(30, 120);
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Result-side backpressure. A stall starts at a random cycle, so it can
    // land on any phase of the block's scan or shift.
    int rsp_stall = 0;
    int rsp_quiet = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rsp_stall > 0) begin
            i_ready <= 1'b0;
            rsp_stall--;
        end else begin
            i_ready <= 1'b1;
            if (rsp_quiet > 0) begin
                rsp_quiet--;
            end else if ($urandom_range(0, 3) == 0) begin
                rsp_stall = pick_gap();
            end else if ($urandom_range(0, 99) == 0) begin
                rsp_quiet = $urandom_range(50, 200);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. On the rising edge it predicts each accepted request and
    // checks each accepted result against the oldest prediction.
    // ------------------------------------------------------------------------
    int            results_seen = 0;
    int            idle_cycles = 0;
    t_table_result want;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            list_len = 0;
            score_reg = '0;
            idle_cycles <= 0;
        end else begin
            req_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                expected_results.push_back(predict_table('{i_func, i_source_address,
                    i_command, i_payload_word, i_payload_ok}));
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("is_trusted", 32'(o_is_trusted), 32'(want.is_trusted));
                    check_field("status", 32'(o_status), 32'(want.status));
                    check_field("entry_count", 32'(o_entry_count), 32'(want.entry_count));
                    check_field("security_score", o_security_score, want.security_score);
                end
                results_seen++;
            end

            // Watchdog: too long without either handshake means a hang.
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("TIMEOUT: no handshake for %0d cycles", STALL_LIMIT);
                $display("trusted_address_table_top regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

// ===== filelist.f =====
hw/rtl/tat_pkg.sv
hw/rtl/tat_ctrl.sv
hw/rtl/tat_dpath.sv
hw/rtl/trusted_address_table_top.sv
tb/tb_top.sv
